[rtl/core/lsch_pkg.sv]
// Package: lottery scheduler constants, control word type and microcode ROM.
`default_nettype none
package lsch_pkg;

	localparam int NUM_PROCS   = 64;
	localparam int NULL_PID    = 0;
	localparam int TICKET_BITS = 16;

	localparam int PID_W   = 6;
	localparam int TCNT_W  = 16;
	localparam int STATE_W = 2;
	localparam int DRAW_W  = 32;
	localparam int TOTAL_W = 22;

	localparam int IDX_W   = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int SUM_W   = TICKET_BITS + IDX_W;
	localparam int NULL_IDX = NULL_PID % NUM_PROCS;
	localparam int DCNT_W  = $clog2(DRAW_W);

	localparam logic [STATE_W-1:0] RS_NONE  = 2'd0;
	localparam logic [STATE_W-1:0] RS_READY = 2'd1;
	localparam logic [STATE_W-1:0] RS_RUN   = 2'd2;

	localparam logic OP_WRITE = 1'b0;

	typedef logic [3:0] step_t;

	localparam step_t SQ_IDLE     = 4'd0;
	localparam step_t SQ_WRITE    = 4'd1;
	localparam step_t SQ_DEM_RD   = 4'd2;
	localparam step_t SQ_DEM_WR   = 4'd3;
	localparam step_t SQ_SUM      = 4'd4;
	localparam step_t SQ_SUM_END  = 4'd5;
	localparam step_t SQ_CHECK    = 4'd6;
	localparam step_t SQ_DIV      = 4'd7;
	localparam step_t SQ_WALK     = 4'd8;
	localparam step_t SQ_WALK_END = 4'd9;
	localparam step_t SQ_WAIT     = 4'd10;
	localparam step_t SQ_WIN      = 4'd11;

	typedef enum logic [2:0] {
		J_NEXT,
		J_ALWAYS,
		J_DISPATCH,
		J_LOOP_SCAN,
		J_LOOP_DIV,
		J_ZERO,
		J_OUT
	} jmp_t;

	typedef struct packed {
		logic  in_rdy;
		logic  wr_entry;
		logic  rd_run;
		logic  demote;
		logic  scan;
		logic  clr;
		logic  acc_sum;
		logic  div_init;
		logic  div_step;
		logic  acc_walk;
		logic  win_wr;
		jmp_t  jmp;
		step_t tgt;
	} ctrl_t;

	function automatic ctrl_t ucode_rom(input step_t s);
		ctrl_t c;
		c = '0;
		c.jmp = J_NEXT;
		c.tgt = SQ_IDLE;
		unique case (s)
			SQ_IDLE: begin
				c.in_rdy = 1'b1;
				c.jmp    = J_DISPATCH;
				c.tgt    = SQ_DEM_RD;
			end
			SQ_WRITE: begin
				c.wr_entry = 1'b1;
				c.jmp      = J_ALWAYS;
				c.tgt      = SQ_IDLE;
			end
			SQ_DEM_RD: begin
				c.rd_run = 1'b1;
				c.clr    = 1'b1;
			end
			SQ_DEM_WR: begin
				c.demote = 1'b1;
			end
			SQ_SUM: begin
				c.scan    = 1'b1;
				c.acc_sum = 1'b1;
				c.jmp     = J_LOOP_SCAN;
				c.tgt     = SQ_SUM;
			end
			SQ_SUM_END: begin
				c.acc_sum = 1'b1;
			end
			SQ_CHECK: begin
				c.div_init = 1'b1;
				c.jmp      = J_ZERO;
				c.tgt      = SQ_WAIT;
			end
			SQ_DIV: begin
				c.div_step = 1'b1;
				c.jmp      = J_LOOP_DIV;
				c.tgt      = SQ_DIV;
			end
			SQ_WALK: begin
				c.scan     = 1'b1;
				c.acc_walk = 1'b1;
				c.jmp      = J_LOOP_SCAN;
				c.tgt      = SQ_WALK;
			end
			SQ_WALK_END: begin
				c.acc_walk = 1'b1;
			end
			SQ_WAIT: begin
				c.jmp = J_OUT;
				c.tgt = SQ_WIN;
			end
			SQ_WIN: begin
				c.win_wr = 1'b1;
				c.jmp    = J_ALWAYS;
				c.tgt    = SQ_IDLE;
			end
			default: begin
				c.jmp = J_ALWAYS;
				c.tgt = SQ_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/core/lsch_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/lottery_scheduler.sv]
// Lottery scheduler: microcoded sequencer over a process ticket and state table.
// Write request: accepted in the idle step, entry written the next cycle.
// Reschedule: time from accept to result is set by two serial table scans
//   and a 32-step bit-serial modulo; a zero total skips the modulo and the walk.
// One request at a time; the result register frees the input side while it waits.
// Reset: asynchronous, clears sequencer, valid bits and running entry; tables read as zero.
`default_nettype none
module lottery_scheduler
	import lsch_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic                op,
	input  wire logic [PID_W-1:0]    pid,
	input  wire logic [TCNT_W-1:0]   ticket_count,
	input  wire logic [STATE_W-1:0]  run_state,
	input  wire logic [DRAW_W-1:0]   random_draw,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [PID_W-1:0]    chosen_pid,
	output      logic [TOTAL_W-1:0]  ticket_total,
	output      logic                none_eligible
);

	ctrl_t                 ctrl;
	step_t                 step_q, step_nxt;
	logic [IDX_W-1:0]      cnt_q;
	logic [DCNT_W-1:0]     dcnt_q;
	logic [IDX_W-1:0]      running_q, win_q, pid_idx;
	logic [NUM_PROCS-1:0]  tval_q, sval_q;
	logic                  tv_s1, sv_s1, scan_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [SUM_W-1:0]      total_q, run_q, rem_q, run_nxt;
	logic [SUM_W:0]        div_sh;
	logic [DRAW_W-1:0]     draw_q;
	logic [PID_W-1:0]      pid_q;
	logic [TCNT_W-1:0]     tcnt_q;
	logic [STATE_W-1:0]    rs_q;
	logic                  found_q, none_q;
	logic                  req_acc, out_free, pid_ok;
	logic                  cnt_last;

	logic                  t_we, s_we;
	logic [IDX_W-1:0]      s_waddr, s_raddr;
	logic [STATE_W-1:0]    s_wdata, s_rdata, st_eff;
	logic [TICKET_BITS-1:0] t_rdata, tk_eff;
	logic                  elig, do_demote;

	assign ctrl     = ucode_rom(step_q);
	assign in_ready = ctrl.in_rdy;
	assign req_acc  = in_valid & ctrl.in_rdy;
	assign out_free = ~out_valid | out_ready;
	assign pid_idx  = IDX_W'(pid_q);
	assign pid_ok   = 32'(pid_q) < 32'(NUM_PROCS);
	assign cnt_last = cnt_q == IDX_W'(NUM_PROCS - 1);

	lsch_ram #(.WIDTH(TICKET_BITS), .DEPTH(NUM_PROCS)) u_ticket_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (pid_idx),
		.wdata (tcnt_q[TICKET_BITS-1:0]),
		.raddr (cnt_q),
		.rdata (t_rdata)
	);

	lsch_ram #(.WIDTH(STATE_W), .DEPTH(NUM_PROCS)) u_state_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign st_eff    = sv_s1 ? s_rdata : RS_NONE;
	assign tk_eff    = tv_s1 ? t_rdata : '0;
	assign elig      = scan_s1 & ((st_eff == RS_READY) | (st_eff == RS_RUN));
	assign do_demote = ctrl.demote & (st_eff == RS_RUN);
	assign run_nxt   = run_q + SUM_W'(tk_eff);
	assign div_sh    = {rem_q, draw_q[DRAW_W-1]};
	assign s_raddr   = ctrl.rd_run ? running_q : cnt_q;
	assign t_we      = ctrl.wr_entry & pid_ok;
	assign s_we      = t_we | do_demote | ctrl.win_wr;

	always_comb begin
		priority if (ctrl.wr_entry) begin
			s_waddr = pid_idx;
			s_wdata = rs_q;
		end else if (ctrl.demote) begin
			s_waddr = running_q;
			s_wdata = RS_READY;
		end else begin
			s_waddr = win_q;
			s_wdata = RS_RUN;
		end
	end

	always_comb begin
		step_nxt = step_t'(step_q + 4'd1);
		unique case (ctrl.jmp)
			J_NEXT:      step_nxt = step_t'(step_q + 4'd1);
			J_ALWAYS:    step_nxt = ctrl.tgt;
			J_DISPATCH: begin
				if (!req_acc) begin
					step_nxt = step_q;
				end else if (op == OP_WRITE) begin
					step_nxt = step_t'(step_q + 4'd1);
				end else begin
					step_nxt = ctrl.tgt;
				end
			end
			J_LOOP_SCAN: step_nxt = cnt_last ? step_t'(step_q + 4'd1) : ctrl.tgt;
			J_LOOP_DIV:  step_nxt = (dcnt_q != '0) ? ctrl.tgt : step_t'(step_q + 4'd1);
			J_ZERO:      step_nxt = (total_q == '0) ? ctrl.tgt : step_t'(step_q + 4'd1);
			J_OUT:       step_nxt = out_free ? ctrl.tgt : step_q;
			default:     step_nxt = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= SQ_IDLE;
			tval_q    <= '0;
			sval_q    <= '0;
			running_q <= IDX_W'(NULL_IDX);
			scan_s1   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			step_q  <= step_nxt;
			scan_s1 <= ctrl.scan;
			if (t_we) begin
				tval_q[pid_idx] <= 1'b1;
			end
			if (s_we) begin
				sval_q[s_waddr] <= 1'b1;
			end
			if (ctrl.win_wr) begin
				running_q <= win_q;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tv_s1  <= tval_q[cnt_q];
		sv_s1  <= sval_q[s_raddr];
		idx_s1 <= cnt_q;
		if (req_acc) begin
			draw_q <= random_draw;
			pid_q  <= pid;
			tcnt_q <= ticket_count;
			rs_q   <= run_state;
		end
		if (ctrl.clr) begin
			cnt_q   <= '0;
			total_q <= '0;
		end
		if (ctrl.scan) begin
			cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
		end
		if (ctrl.acc_sum && elig) begin
			total_q <= total_q + SUM_W'(tk_eff);
		end
		if (ctrl.div_init) begin
			rem_q   <= '0;
			dcnt_q  <= DCNT_W'(DRAW_W - 1);
			run_q   <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			win_q   <= IDX_W'(NULL_IDX);
			none_q  <= total_q == '0;
		end
		if (ctrl.div_step) begin
			if (div_sh >= {1'b0, total_q}) begin
				rem_q <= SUM_W'(div_sh - {1'b0, total_q});
			end else begin
				rem_q <= div_sh[SUM_W-1:0];
			end
			draw_q <= draw_q << 1;
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
		if (ctrl.acc_walk && elig && !found_q) begin
			run_q <= run_nxt;
			if (run_nxt > rem_q) begin
				found_q <= 1'b1;
				win_q   <= idx_s1;
			end
		end
		if (ctrl.win_wr) begin
			chosen_pid    <= PID_W'(win_q);
			ticket_total  <= TOTAL_W'(total_q);
			none_eligible <= none_q;
		end
	end

endmodule
`default_nettype wire

[dv/lottery_scheduler_test.sv]
// Self-checking testbench for the lottery scheduler: random table writes and reschedules.
module lottery_scheduler_test;
	import lsch_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_RESCHED = ~OP_WRITE;
	localparam logic [STATE_W-1:0] RS_UNUSED = 2'd3;
	localparam longint unsigned TKT_MASK = (64'd1 << TICKET_BITS) - 1;
	localparam int RAND_ITEMS = 1950;
	localparam int SETTLE_CYCLES = 2 * NUM_PROCS + 80;
	localparam int LIMIT = 2_500_000;

	typedef struct {
		logic                op;
		logic [PID_W-1:0]    pid;
		logic [TCNT_W-1:0]   tickets;
		logic [STATE_W-1:0]  state;
		logic [DRAW_W-1:0]   draw;
		bit                  drain;
	} request_t;

	typedef struct {
		logic [PID_W-1:0]    pid;
		logic [TOTAL_W-1:0]  total;
		logic                none;
	} grant_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                op = OP_WRITE;
	logic [PID_W-1:0]    pid = '0;
	logic [TCNT_W-1:0]   ticket_count = '0;
	logic [STATE_W-1:0]  run_state = RS_NONE;
	logic [DRAW_W-1:0]   random_draw = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [PID_W-1:0]    chosen_pid;
	logic [TOTAL_W-1:0]  ticket_total;
	logic                none_eligible;

	request_t requests_todo[$];
	grant_t   grants_due[$];
	request_t in_flight;

	logic [TCNT_W-1:0]  tkt_table [NUM_PROCS];
	logic [STATE_W-1:0] state_table [NUM_PROCS];
	int                 run_idx;

	int errors = 0;
	int cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	int rx_left = 0;

	lottery_scheduler u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.pid           (pid),
		.ticket_count  (ticket_count),
		.run_state     (run_state),
		.random_draw   (random_draw),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.chosen_pid    (chosen_pid),
		.ticket_total  (ticket_total),
		.none_eligible (none_eligible)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_eligible(input int i);
		return state_table[i] == RS_READY || state_table[i] == RS_RUN;
	endfunction

	function automatic void track_request(input request_t r);
		longint unsigned sum;
		longint unsigned acc;
		longint unsigned pick;
		int i;
		int win;
		bit hit;
		grant_t g;
		if (r.op == OP_WRITE) begin
			if (r.pid < NUM_PROCS) begin
				tkt_table[r.pid] = TCNT_W'(r.tickets & TKT_MASK);
				state_table[r.pid] = r.state;
			end
			return;
		end
		if (run_idx < NUM_PROCS && state_table[run_idx] == RS_RUN)
			state_table[run_idx] = RS_READY;
		sum = 0;
		for (i = 0; i < NUM_PROCS; i++)
			if (is_eligible(i))
				sum += tkt_table[i];
		win = NULL_IDX;
		if (sum != 0) begin
			pick = longint'(r.draw) % sum;
			acc = 0;
			hit = 1'b0;
			for (i = 0; i < NUM_PROCS; i++) begin
				if (!hit && is_eligible(i)) begin
					acc += tkt_table[i];
					if (acc > pick) begin
						win = i;
						hit = 1'b1;
					end
				end
			end
		end
		state_table[win] = RS_RUN;
		run_idx = win;
		g.pid = PID_W'(win);
		g.total = TOTAL_W'(sum);
		g.none = (sum == 0);
		grants_due.push_back(g);
	endfunction

	task automatic add_write(input int p, input int tc, input logic [STATE_W-1:0] st,
		input bit hold);
		request_t r;
		r.op = OP_WRITE;
		r.pid = PID_W'(p);
		r.tickets = TCNT_W'(tc);
		r.state = st;
		r.draw = $urandom;
		r.drain = hold;
		requests_todo.push_back(r);
	endtask

	task automatic add_resched(input logic [DRAW_W-1:0] d, input bit hold);
		request_t r;
		r.op = OP_RESCHED;
		r.pid = PID_W'($urandom);
		r.tickets = TCNT_W'($urandom);
		r.state = STATE_W'($urandom);
		r.draw = d;
		r.drain = hold;
		requests_todo.push_back(r);
	endtask

	function automatic logic [DRAW_W-1:0] rand_draw();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_tickets();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 16'hFFFF;
			2, 3: return $urandom_range(1, 15);
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	function automatic logic [STATE_W-1:0] rand_state();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60)
			return RS_READY;
		else if (k < 75)
			return RS_RUN;
		else if (k < 90)
			return RS_NONE;
		return RS_UNUSED;
	endfunction

	always @(posedge clk) begin : drive
		logic nv;
		request_t r;
		nv = in_valid;
		if (!arst_n) begin
			nv = 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_request(in_flight);
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (requests_todo.size() > 0 &&
					!(requests_todo[0].drain && grants_due.size() > 0)) begin
					r = requests_todo.pop_front();
					in_flight = r;
					op <= r.op;
					pid <= r.pid;
					ticket_count <= r.tickets;
					run_state <= r.state;
					random_draw <= r.draw;
					nv = 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 3) == 1 ? $urandom_range(20, 64)
							: $urandom_range(1, 12);
						gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40)
							: $urandom_range(0, 4);
					end
				end
			end
		end
		in_valid <= nv;
	end

	always @(posedge clk) begin : receive
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_left > 0) begin
			rx_left--;
		end else if (out_ready) begin
			rx_left = $urandom_range(0, 9) < 3 ? $urandom_range(20, 80) : $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			rx_left = $urandom_range(1, 200);
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check
		grant_t g;
		if (arst_n && out_valid && out_ready) begin
			if (grants_due.size() == 0) begin
				$error("chosen_pid: no request pending, got %0d", chosen_pid);
				errors++;
			end else begin
				g = grants_due.pop_front();
				if (chosen_pid !== g.pid) begin
					$error("chosen_pid: expected %0d, got %0d", g.pid, chosen_pid);
					errors++;
				end
				if (ticket_total !== g.total) begin
					$error("ticket_total: expected %0d, got %0d", g.total, ticket_total);
					errors++;
				end
				if (none_eligible !== g.none) begin
					$error("none_eligible: expected %0d, got %0d", g.none, none_eligible);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int p, base, span, n, k, queued;
		logic [STATE_W-1:0] st;
		for (p = 0; p < NUM_PROCS; p++) begin
			tkt_table[p] = '0;
			state_table[p] = RS_NONE;
		end
		run_idx = NULL_IDX;

		add_resched($urandom, 1'b0);
		add_write(NUM_PROCS - 1, 16'hFFFF, RS_READY, 1'b0);
		add_write(0, 1, RS_RUN, 1'b0);
		add_write(5, 16'h8000, RS_UNUSED, 1'b0);
		add_resched('0, 1'b0);
		add_resched('1, 1'b0);
		add_write(10, 100, RS_RUN, 1'b0);
		add_resched(1, 1'b0);
		add_write(NUM_PROCS - 1, 0, RS_READY, 1'b0);
		add_write(0, 0, RS_NONE, 1'b0);
		add_write(10, 0, RS_NONE, 1'b0);
		add_resched(32'h1234_5678, 1'b0);
		add_write(42, 16'hAAAA, RS_READY, 1'b0);
		add_write(21, 16'h5555, RS_READY, 1'b0);
		add_resched(32'h5555_5555, 1'b0);
		add_resched(32'hAAAA_AAAA, 1'b0);
		add_write(1, 16'hFFFF, RS_RUN, 1'b0);
		add_write(2, 16'h7FFF, RS_RUN, 1'b0);
		add_resched('0, 1'b1);
		add_resched('1, 1'b0);

		queued = 0;
		while (queued < RAND_ITEMS) begin
			k = $urandom_range(0, 99);
			if (k < 6) begin
				// clear the table so nothing eligible holds tickets
				for (p = 0; p < NUM_PROCS; p++) begin
					st = STATE_W'($urandom_range(0, 3));
					add_write(p, (st == RS_READY || st == RS_RUN) ? 0 : $urandom, st,
						p == 0);
				end
				add_resched(rand_draw(), 1'b0);
				queued += NUM_PROCS + 1;
			end else if (k < 9) begin
				// load every entry near the top of the ticket range
				for (p = 0; p < NUM_PROCS; p++)
					add_write(p, $urandom_range(0, 1) ? 16'hFFFF : $urandom_range(16'hF000,
						16'hFFFF), $urandom_range(0, 4) ? RS_READY : RS_RUN, 1'b0);
				n = $urandom_range(1, 4);
				for (p = 0; p < n; p++)
					add_resched(rand_draw(), 1'b0);
				queued += NUM_PROCS + n;
			end else begin
				base = $urandom_range(0, NUM_PROCS - 1);
				span = $urandom_range(1, 16);
				n = $urandom_range(0, 6);
				for (p = 0; p < n; p++)
					add_write((base + $urandom_range(0, span - 1)) % NUM_PROCS,
						rand_tickets(), rand_state(), 1'b0);
				queued += n;
				n = $urandom_range(1, 3);
				for (p = 0; p < n; p++)
					add_resched(rand_draw(), $urandom_range(0, 199) == 0);
				queued += n;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (requests_todo.size() > 0 || in_valid)
			@(posedge clk);
		while (grants_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0 && grants_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
rtl/core/lsch_pkg.sv
rtl/core/lsch_ram.sv
rtl/core/lottery_scheduler.sv
dv/lottery_scheduler_test.sv
